[rtl/farq_pkg.sv]
`default_nettype none
package farq_pkg;

   localparam int FIELD_ID_W = 16;
   localparam int SLOT_W     = 6;
   localparam int CFG_W      = 7;
   localparam int REL_W      = 2;

   typedef logic [FIELD_ID_W-1:0] id_field_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [CFG_W-1:0]      cfg_type;
   typedef logic [REL_W-1:0]      rel_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam rel_type REL_NONE      = 2'd0;
   localparam rel_type REL_B_OVER_A  = 2'd1;
   localparam rel_type REL_A_OVER_B  = 2'd2;
   localparam rel_type REL_SAME_ROOT = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND_A,
      S_FIND_B,
      S_SCAN,
      S_READ,
      S_EVAL,
      S_RESULT
   } state_type;

   typedef enum logic [1:0] {
      PH_ANC_A,
      PH_ANC_B,
      PH_ROOT_A,
      PH_ROOT_B
   } phase_type;

   typedef enum logic [1:0] {
      KEY_REQ,
      KEY_B,
      KEY_PARENT
   } key_sel_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_SA,
      CUR_SB,
      CUR_HIT
   } cur_sel_type;

   typedef struct packed {
      logic        idle;
      logic        scan_start;
      key_sel_type key_sel;
      logic        scan_run;
      logic        save_sa;
      logic        save_sb;
      cur_sel_type cur_sel;
      logic        steps_clr;
      logic        steps_inc;
      logic        rd_cur;
      logic        save_root;
      logic        set_result;
      rel_type     rel;
      logic        broken;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic req_query;
      logic scan_hit;
      logic scan_miss;
      logic is_root;
      logic par_eq_a;
      logic par_eq_b;
      logic steps_done;
      logic same_root;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

[rtl/farq_intf.sv]
`default_nettype none
interface farq_req_if;
   import farq_pkg::*;
   logic         valid;
   logic         ready;
   logic         opcode;
   slot_type     slot;
   id_field_type node_id;
   id_field_type parent_id;
   id_field_type first_id;
   id_field_type second_id;

   modport source (output valid, output opcode, output slot, output node_id,
                   output parent_id, output first_id, output second_id, input ready);
   modport sink (input valid, input opcode, input slot, input node_id,
                 input parent_id, input first_id, input second_id, output ready);
endinterface

interface farq_rsp_if;
   import farq_pkg::*;
   logic    valid;
   logic    ready;
   rel_type relation;
   logic    broken_chain;

   modport source (output valid, output relation, output broken_chain, input ready);
   modport sink (input valid, input relation, input broken_chain, output ready);
endinterface

interface farq_csr_if;
   import farq_pkg::*;
   logic    valid;
   logic    ready;
   cfg_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/farq_ram.sv]
`default_nettype none
module farq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/farq_ctrl.sv]
`default_nettype none
module farq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire farq_pkg::status_type sts,
   output farq_pkg::cmd_type        cmd
);
   import farq_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_ANC_A;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         S_IDLE: begin
            if (sts.req_query) state_in = S_FIND_A;
         end
         S_FIND_A: begin
            if (sts.scan_hit) state_in = S_FIND_B;
            else if (sts.scan_miss) state_in = S_RESULT;
         end
         S_FIND_B: begin
            if (sts.scan_hit) begin
               state_in = S_READ;
               phase_in = PH_ANC_A;
            end else if (sts.scan_miss) begin
               state_in = S_RESULT;
            end
         end
         S_SCAN: begin
            if (sts.scan_hit) state_in = S_READ;
            else if (sts.scan_miss) state_in = S_RESULT;
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            case (phase_ff)
               PH_ANC_A: begin
                  if (sts.is_root) begin
                     phase_in = PH_ANC_B;
                     state_in = S_READ;
                  end else if (sts.par_eq_b || sts.steps_done) begin
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               PH_ANC_B: begin
                  if (sts.is_root) begin
                     phase_in = PH_ROOT_A;
                     state_in = S_READ;
                  end else if (sts.par_eq_a || sts.steps_done) begin
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               PH_ROOT_A: begin
                  if (sts.is_root) begin
                     phase_in = PH_ROOT_B;
                     state_in = S_READ;
                  end else if (sts.steps_done) begin
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  if (sts.is_root || sts.steps_done) state_in = S_RESULT;
                  else state_in = S_SCAN;
               end
            endcase
         end
         S_RESULT: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.key_sel = KEY_REQ;
      cmd.cur_sel = CUR_HOLD;
      cmd.rel = REL_NONE;
      case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (sts.req_query) begin
               cmd.scan_start = 1'b1;
               cmd.key_sel = KEY_REQ;
            end
         end
         S_FIND_A: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_hit) begin
               cmd.save_sa = 1'b1;
               cmd.scan_start = 1'b1;
               cmd.key_sel = KEY_B;
            end else if (sts.scan_miss) begin
               cmd.set_result = 1'b1;
               cmd.broken = 1'b1;
            end
         end
         S_FIND_B: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_hit) begin
               cmd.save_sb = 1'b1;
               cmd.cur_sel = CUR_SA;
               cmd.steps_clr = 1'b1;
            end else if (sts.scan_miss) begin
               cmd.set_result = 1'b1;
               cmd.broken = 1'b1;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_hit) begin
               cmd.cur_sel = CUR_HIT;
            end else if (sts.scan_miss) begin
               cmd.set_result = 1'b1;
               cmd.broken = 1'b1;
            end
         end
         S_READ: begin
            cmd.rd_cur = 1'b1;
         end
         S_EVAL: begin
            if (sts.is_root) begin
               case (phase_ff)
                  PH_ANC_A: begin
                     cmd.cur_sel = CUR_SB;
                     cmd.steps_clr = 1'b1;
                  end
                  PH_ANC_B: begin
                     cmd.cur_sel = CUR_SA;
                     cmd.steps_clr = 1'b1;
                  end
                  PH_ROOT_A: begin
                     cmd.save_root = 1'b1;
                     cmd.cur_sel = CUR_SB;
                     cmd.steps_clr = 1'b1;
                  end
                  default: begin
                     cmd.set_result = 1'b1;
                     cmd.rel = sts.same_root ? REL_SAME_ROOT : REL_NONE;
                  end
               endcase
            end else if (phase_ff == PH_ANC_A && sts.par_eq_b) begin
               cmd.set_result = 1'b1;
               cmd.rel = REL_B_OVER_A;
            end else if (phase_ff == PH_ANC_B && sts.par_eq_a) begin
               cmd.set_result = 1'b1;
               cmd.rel = REL_A_OVER_B;
            end else if (sts.steps_done) begin
               cmd.set_result = 1'b1;
               cmd.broken = 1'b1;
            end else begin
               cmd.steps_inc = 1'b1;
               cmd.scan_start = 1'b1;
               cmd.key_sel = KEY_PARENT;
            end
         end
         S_RESULT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            cmd.idle = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/farq_dpath.sv]
`default_nettype none
module farq_dpath #(
   parameter int ENTRIES = 64,
   parameter int ID_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   farq_req_if.sink                  req_chan,
   farq_rsp_if.source                rsp_chan,
   farq_csr_if.sink                  csr_chan,
   input  wire farq_pkg::cmd_type    cmd,
   output farq_pkg::status_type      sts
);
   import farq_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   cfg_type            entry_count_ff, entry_count_in;
   logic [CNT_W-1:0]   n_srch;
   logic [ID_BITS-1:0] a_ff, a_in, b_ff, b_in, key_ff, key_in, ra_ff, ra_in;
   logic [CNT_W-1:0]   issue_ff, issue_in, steps_ff, steps_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   sa_ff, sa_in, sb_ff, sb_in, cur_ff, cur_in;
   rel_type            res_rel_ff, res_rel_in, rsp_rel_ff, rsp_rel_in;
   logic               res_broken_ff, res_broken_in, rsp_broken_ff, rsp_broken_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic               wr_en;
   logic [IDX_W-1:0]   node_rd_addr;
   logic [ID_BITS-1:0] node_q, par_q;
   logic               issue_more;

   // searched slot count, clamped to the table size
   always_comb begin
      if (32'(entry_count_ff) > ENTRIES) n_srch = CNT_W'(ENTRIES);
      else n_srch = CNT_W'(entry_count_ff);
   end

   assign accept = cmd.idle && req_chan.valid;
   assign wr_en = accept && (req_chan.opcode == OP_WRITE) && (32'(req_chan.slot) < ENTRIES);
   assign issue_more = issue_ff < n_srch;
   assign node_rd_addr = cmd.rd_cur ? cur_ff : issue_ff[IDX_W-1:0];

   farq_ram #(.WIDTH(ID_BITS), .DEPTH(ENTRIES)) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_chan.slot)),
      .wr_data (ID_BITS'(req_chan.node_id)),
      .rd_addr (node_rd_addr),
      .rd_data (node_q)
   );

   farq_ram #(.WIDTH(ID_BITS), .DEPTH(ENTRIES)) u_parent_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_chan.slot)),
      .wr_data (ID_BITS'(req_chan.parent_id)),
      .rd_addr (cur_ff),
      .rd_data (par_q)
   );

   assign req_chan.ready = cmd.idle;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.relation = rsp_rel_ff;
   assign rsp_chan.broken_chain = rsp_broken_ff;

   always_comb begin
      sts.req_query  = req_chan.valid && (req_chan.opcode == OP_QUERY);
      sts.scan_hit   = rd_valid_ff && (node_q == key_ff);
      sts.scan_miss  = !rd_valid_ff && !issue_more;
      sts.is_root    = node_q == par_q;
      sts.par_eq_a   = par_q == a_ff;
      sts.par_eq_b   = par_q == b_ff;
      sts.steps_done = steps_ff >= n_srch;
      sts.same_root  = node_q == ra_ff;
      sts.out_free   = !rsp_valid_ff || rsp_chan.ready;
   end

   always_comb begin
      entry_count_in = entry_count_ff;
      a_in = a_ff;
      b_in = b_ff;
      key_in = key_ff;
      ra_in = ra_ff;
      issue_in = issue_ff;
      steps_in = steps_ff;
      rd_valid_in = rd_valid_ff;
      rd_idx_in = rd_idx_ff;
      sa_in = sa_ff;
      sb_in = sb_ff;
      cur_in = cur_ff;
      res_rel_in = res_rel_ff;
      res_broken_in = res_broken_ff;
      rsp_rel_in = rsp_rel_ff;
      rsp_broken_in = rsp_broken_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_chan.valid) entry_count_in = csr_chan.data;

      if (accept) begin
         a_in = ID_BITS'(req_chan.first_id);
         b_in = ID_BITS'(req_chan.second_id);
      end

      // linear search of the node id memory, one slot issued per cycle
      if (cmd.scan_run) begin
         rd_valid_in = issue_more;
         rd_idx_in = issue_ff[IDX_W-1:0];
         if (issue_more) issue_in = issue_ff + 1'b1;
      end

      if (cmd.save_sa) sa_in = rd_idx_ff;
      if (cmd.save_sb) sb_in = rd_idx_ff;

      case (cmd.cur_sel)
         CUR_SA:  cur_in = sa_ff;
         CUR_SB:  cur_in = sb_ff;
         CUR_HIT: cur_in = rd_idx_ff;
         default: cur_in = cur_ff;
      endcase

      if (cmd.scan_start) begin
         issue_in = '0;
         rd_valid_in = 1'b0;
         case (cmd.key_sel)
            KEY_REQ:    key_in = ID_BITS'(req_chan.first_id);
            KEY_B:      key_in = b_ff;
            KEY_PARENT: key_in = par_q;
            default:    key_in = key_ff;
         endcase
      end

      if (cmd.steps_clr) steps_in = '0;
      else if (cmd.steps_inc) steps_in = steps_ff + 1'b1;

      if (cmd.save_root) ra_in = node_q;

      if (cmd.set_result) begin
         res_rel_in = cmd.rel;
         res_broken_in = cmd.broken;
      end

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_rel_in = res_rel_ff;
         rsp_broken_in = res_broken_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
         issue_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff <= rd_valid_in;
         issue_ff <= issue_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      key_ff <= key_in;
      ra_ff <= ra_in;
      steps_ff <= steps_in;
      rd_idx_ff <= rd_idx_in;
      sa_ff <= sa_in;
      sb_ff <= sb_in;
      cur_ff <= cur_in;
      res_rel_ff <= res_rel_in;
      res_broken_ff <= res_broken_in;
      rsp_rel_ff <= rsp_rel_in;
      rsp_broken_ff <= rsp_broken_in;
   end

endmodule
`default_nettype wire

[rtl/forest_ancestor_relation_query.sv]
// write word: no response word; one query word is in flight at a time.
// query word, n = min(entry_count, ENTRIES): an id search reads one slot per cycle over
//   the first n slots; a parent step is a search plus a read of the current slot.
// the walk of a query is serialised by the single read port of the node id memory;
//   a result waits in an output register while the next word enters.
// reset (synchronous, active high) clears control state and entry_count; table undefined.
`default_nettype none
module forest_ancestor_relation_query #(
   parameter int ENTRIES = 64,
   parameter int ID_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   farq_req_if.sink   req_chan,
   farq_rsp_if.source rsp_chan,
   farq_csr_if.sink   csr_chan
);
   import farq_pkg::*;

   cmd_type    cmd;
   status_type sts;

   farq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   farq_dpath #(.ENTRIES(ENTRIES), .ID_BITS(ID_BITS)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .sts      (sts)
   );

`ifndef SYNTHESIS
   // a new result only appears after the controller released it
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.emit))
      else $error("result valid without emit");

   // never overwrite a result that has not been taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("emit while output register busy");

   // no word is taken while a query walks the table
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> (!cmd.scan_run && !cmd.rd_cur))
      else $error("word accepted during a query");
`endif

endmodule
`default_nettype wire

[tb/tb_forest_ancestor_relation_query.sv]
module tb_forest_ancestor_relation_query;
   import farq_pkg::*;

   localparam int TABLE_SLOTS    = 64;
   localparam int RANDOM_WORDS   = 2000;
   localparam int LONG_HOLD      = 3000;
   localparam int WATCHDOG_LIMIT = 100000;

   // receiver stall modes
   localparam int RX_OPEN    = 0;
   localparam int RX_COIN    = 1;
   localparam int RX_PATTERN = 2;
   localparam int RX_SPARSE  = 3;

   typedef struct packed {
      rel_type relation;
      logic    broken_chain;
   } answer_type;

   logic clock;
   logic reset;

   farq_req_if req_if ();
   farq_rsp_if rsp_if ();
   farq_csr_if csr_if ();

   // shadow copy of the node table and the searched-slot count
   id_field_type tbl_node   [TABLE_SLOTS];
   id_field_type tbl_parent [TABLE_SLOTS];
   cfg_type      live_count = '0;
   answer_type   pending_answers [$];
   answer_type   want_ans;

   int unsigned words_sent   = 0;
   int unsigned mismatches   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned burst_left   = 0;
   bit          gaps_on      = 1'b1;
   bit          hold_request = 1'b0;

   int          rx_mode = RX_OPEN;
   int unsigned rx_left = 0;
   int unsigned rx_hold = 0;
   logic [15:0] rx_pattern = '0;
   logic [3:0]  rx_idx = '0;

   forest_ancestor_relation_query #(
      .ENTRIES(TABLE_SLOTS),
      .ID_BITS(FIELD_ID_W)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------- relation predictor ----------------

   function automatic int unsigned scan_limit();
      return (live_count > TABLE_SLOTS) ? TABLE_SLOTS : live_count;
   endfunction

   function automatic bit locate_id(id_field_type id, output int unsigned where);
      int unsigned lim;
      lim = scan_limit();
      for (int unsigned i = 0; i < lim; i++) begin
         if (tbl_node[i] == id) begin
            where = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // 1: some node on the way up has target as parent, 0: hit a root, -1: broken
   function automatic int climb_for(int unsigned start, id_field_type target);
      int unsigned lim, steps, at, nxt;
      lim = scan_limit();
      steps = 0;
      at = start;
      while (tbl_node[at] != tbl_parent[at]) begin
         if (tbl_parent[at] == target)
            return 1;
         if (steps >= lim)
            return -1;
         steps++;
         if (!locate_id(tbl_parent[at], nxt))
            return -1;
         at = nxt;
      end
      return 0;
   endfunction

   function automatic bit climb_root(int unsigned start, output id_field_type root);
      int unsigned lim, steps, at, nxt;
      lim = scan_limit();
      steps = 0;
      at = start;
      while (tbl_node[at] != tbl_parent[at]) begin
         if (steps >= lim)
            return 1'b0;
         steps++;
         if (!locate_id(tbl_parent[at], nxt))
            return 1'b0;
         at = nxt;
      end
      root = tbl_node[at];
      return 1'b1;
   endfunction

   function automatic answer_type predict_relation(id_field_type a, id_field_type b);
      answer_type   ans;
      int unsigned  sa, sb;
      id_field_type ra, rb;
      int           r;
      ans.relation = REL_NONE;
      ans.broken_chain = 1'b1;
      if (!locate_id(a, sa) || !locate_id(b, sb))
         return ans;
      r = climb_for(sa, b);
      if (r < 0)
         return ans;
      if (r > 0) begin
         ans.relation = REL_B_OVER_A;
         ans.broken_chain = 1'b0;
         return ans;
      end
      r = climb_for(sb, a);
      if (r < 0)
         return ans;
      if (r > 0) begin
         ans.relation = REL_A_OVER_B;
         ans.broken_chain = 1'b0;
         return ans;
      end
      if (!climb_root(sa, ra) || !climb_root(sb, rb))
         return ans;
      ans.relation = (ra == rb) ? REL_SAME_ROOT : REL_NONE;
      ans.broken_chain = 1'b0;
      return ans;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic bit chance(int unsigned pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic id_field_type rand_id();
      return id_field_type'($urandom_range(0, 65535));
   endfunction

   function automatic id_field_type known_id(int unsigned m);
      return tbl_node[$urandom_range(0, m - 1)];
   endfunction

   function automatic id_field_type chain_id(int i);
      return id_field_type'(16'h4000 + i * 16'h0101);
   endfunction

   task automatic pace_sender();
      int unsigned gap;
      if (!gaps_on)
         return;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 15);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic send_word(logic op, slot_type s, id_field_type nid, id_field_type pid,
                            id_field_type fa, id_field_type fb);
      req_if.valid     <= 1'b1;
      req_if.opcode    <= op;
      req_if.slot      <= s;
      req_if.node_id   <= nid;
      req_if.parent_id <= pid;
      req_if.first_id  <= fa;
      req_if.second_id <= fb;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      words_sent++;
      if (op == OP_WRITE) begin
         tbl_node[s]   = nid;
         tbl_parent[s] = pid;
      end else begin
         pending_answers.push_back(predict_relation(fa, fb));
      end
   endtask

   task automatic send_entry(slot_type s, id_field_type nid, id_field_type pid);
      pace_sender();
      send_word(OP_WRITE, s, nid, pid, rand_id(), rand_id());
   endtask

   task automatic send_query(id_field_type a, id_field_type b);
      pace_sender();
      send_word(OP_QUERY, slot_type'($urandom_range(0, TABLE_SLOTS - 1)), rand_id(),
                rand_id(), a, b);
   endtask

   // always advances the clock so valid never gets two updates in a step
   task automatic wait_answers();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic write_entry_count(cfg_type value);
      wait_answers();
      // a trailing table write has no response word, give it time to land
      repeat (8) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      live_count = value;
   endtask

   // mostly a well-formed forest, with some duplicate ids, dangling and forward parents
   task automatic build_forest(int unsigned m);
      id_field_type ids [TABLE_SLOTS];
      id_field_type par;
      int unsigned  r;
      for (int i = 0; i < m; i++) begin
         if (i > 0 && chance(8))
            ids[i] = ids[$urandom_range(0, i - 1)];
         else
            ids[i] = rand_id();
      end
      for (int i = 0; i < m; i++) begin
         r = $urandom_range(0, 99);
         if (i == 0 || r < 30)
            par = ids[i];
         else if (r < 85)
            par = ids[$urandom_range(0, i - 1)];
         else if (r < 93)
            par = rand_id();
         else
            par = ids[$urandom_range(i, m - 1)];
         send_entry(slot_type'(i), ids[i], par);
      end
   endtask

   task automatic random_query(int unsigned m);
      id_field_type a, b;
      a = (m > 0 && chance(85)) ? known_id(m) : rand_id();
      b = (m > 0 && chance(85)) ? known_id(m) : rand_id();
      if (chance(10))
         b = a;
      send_query(a, b);
   endtask

   task automatic random_rewrite(int unsigned m);
      slot_type     s;
      id_field_type nid, pid;
      int unsigned  r;
      if (chance(85))
         s = slot_type'($urandom_range(0, m - 1));
      else
         s = slot_type'($urandom_range(0, TABLE_SLOTS - 1));
      nid = chance(50) ? tbl_node[s] : rand_id();
      r = $urandom_range(0, 99);
      if (r < 50)
         pid = known_id(m);
      else if (r < 80)
         pid = nid;
      else
         pid = rand_id();
      send_entry(s, nid, pid);
   endtask

   // ---------------- tests ----------------

   task automatic test_directed_cases();
      gaps_on = 1'b1;
      // nothing searched: every lookup misses
      write_entry_count(cfg_type'(0));
      send_query(16'h0000, 16'hFFFF);
      write_entry_count(cfg_type'(7));
      send_entry(slot_type'(0), 16'h0000, 16'h0000);
      send_entry(slot_type'(1), 16'hFFFF, 16'h0000);
      send_entry(slot_type'(2), 16'h1234, 16'hFFFF);
      send_entry(slot_type'(3), 16'h00FF, 16'h00FF);
      // two-node loop
      send_entry(slot_type'(4), 16'h5AAA, 16'h5555);
      send_entry(slot_type'(5), 16'h5555, 16'h5AAA);
      // parent that is not in the table
      send_entry(slot_type'(6), 16'hABCD, 16'h7777);
      send_query(16'h1234, 16'h0000);
      send_query(16'h0000, 16'h1234);
      send_query(16'h1234, 16'hFFFF);
      send_query(16'hFFFF, 16'h1234);
      send_query(16'h1234, 16'h00FF);
      send_query(16'h1234, 16'h1234);
      send_query(16'hFFFF, 16'hFFFF);
      send_query(16'h5555, 16'h00FF);
      send_query(16'hABCD, 16'h0000);
      send_query(16'h4321, 16'h0000);
      send_query(16'h0000, 16'h4321);
   endtask

   task automatic test_full_table();
      gaps_on = 1'b1;
      write_entry_count(cfg_type'(TABLE_SLOTS));
      // one deep chain over every slot
      for (int i = 0; i < TABLE_SLOTS; i++)
         send_entry(slot_type'(i), chain_id(i), (i == 0) ? chain_id(0) : chain_id(i - 1));
      send_query(chain_id(63), chain_id(0));
      send_query(chain_id(0), chain_id(63));
      send_query(chain_id(63), chain_id(63));
      send_query(chain_id(40), chain_id(41));
      // count above the table size still searches the whole table
      write_entry_count(cfg_type'(127));
      send_query(chain_id(63), chain_id(0));
      send_entry(slot_type'(0), chain_id(0), chain_id(1));
      send_query(chain_id(5), chain_id(63));
      send_entry(slot_type'(50), chain_id(3), chain_id(3));
      send_query(chain_id(3), chain_id(2));
      send_query(chain_id(60), chain_id(10));
   endtask

   task automatic test_backpressure();
      write_entry_count(cfg_type'(8));
      gaps_on = 1'b1;
      build_forest(8);
      // receiver holds off while queries keep coming without gaps
      gaps_on = 1'b0;
      hold_request = 1'b1;
      repeat (30) random_query(8);
      wait_answers();
      gaps_on = 1'b1;
      repeat (20) random_query(8);
   endtask

   task automatic test_random_forests(int unsigned budget);
      int unsigned stop_at, cnt, m, n_ops, r;
      stop_at = words_sent + budget;
      while (words_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 4)
            cnt = 0;
         else if (r < 8)
            cnt = 1;
         else if (r < 12)
            cnt = $urandom_range(TABLE_SLOTS, 127);
         else if (r < 22)
            cnt = $urandom_range(13, 24);
         else
            cnt = $urandom_range(2, 12);
         write_entry_count(cfg_type'(cnt));
         m = (cnt > TABLE_SLOTS) ? TABLE_SLOTS : cnt;
         gaps_on = chance(75);
         burst_left = 0;
         build_forest(m);
         if (m >= 32)
            n_ops = $urandom_range(6, 12);
         else if (m == 0)
            n_ops = $urandom_range(3, 6);
         else
            n_ops = $urandom_range(15, 50);
         repeat (n_ops) begin
            if (m > 0 && chance(15))
               random_rewrite(m);
            else
               random_query(m);
         end
      end
   endtask

   task automatic finish_run();
      wait_answers();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("forest_ancestor_relation_query regression: pass");
      else
         $display("forest_ancestor_relation_query regression: fail");
      $finish;
   endtask

   initial begin
      req_if.valid     <= 1'b0;
      req_if.opcode    <= OP_WRITE;
      req_if.slot      <= '0;
      req_if.node_id   <= '0;
      req_if.parent_id <= '0;
      req_if.first_id  <= '0;
      req_if.second_id <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.data      <= '0;
      reset            <= 1'b1;
      foreach (tbl_node[i]) begin
         tbl_node[i]   = '0;
         tbl_parent[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_full_table();
      test_backpressure();
      test_random_forests(RANDOM_WORDS);
      finish_run();
   end

   // ---------------- result side ----------------

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            rx_hold = 0;
            while (rx_hold < LONG_HOLD) begin
               @(posedge clock);
               rx_hold++;
            end
         end else begin
            if (rx_left == 0) begin
               rx_mode    = $urandom_range(RX_OPEN, RX_SPARSE);
               rx_left    = $urandom_range(32, 400);
               rx_pattern = 16'($urandom());
            end
            rx_left--;
            rx_idx++;
            case (rx_mode)
               RX_OPEN: begin
                  rsp_if.ready <= 1'b1;
               end
               RX_COIN: begin
                  rsp_if.ready <= chance(50);
               end
               RX_PATTERN: begin
                  rsp_if.ready <= rx_pattern[rx_idx];
               end
               default: begin
                  rsp_if.ready <= chance(25);
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: relation %0d broken_chain %0b",
                        rsp_if.relation, rsp_if.broken_chain);
         end else begin
            want_ans = pending_answers.pop_front();
            if (rsp_if.relation !== want_ans.relation ||
                rsp_if.broken_chain !== want_ans.broken_chain) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected relation %0d broken_chain %0b, %s %0d %0b",
                           want_ans.relation, want_ans.broken_chain, "got",
                           rsp_if.relation, rsp_if.broken_chain);
            end
         end
      end
   end

   // watchdog on cycles with no word moving on any channel
   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (csr_if.valid === 1'b1 && csr_if.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("forest_ancestor_relation_query regression: fail");
         $finish;
      end
   end

endmodule
